### rtl/core/mcpe_pkg.sv
// ----------------------------------------------------------------------------
// mcpe_pkg
// shared types, constants and helpers of the mask contour point extractor
// ----------------------------------------------------------------------------
package mcpe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 7;
    localparam int BORDER     = 3;

    // field widths
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int COUNT_W = 21;
    localparam int PIXEL_W = 32;

    // line store: one entry per column, {upper row flag, middle row flag}
    localparam int LINE_DEPTH   = MAX_WIDTH;
    localparam int LINE_ENTRY_W = 2;

    // result queue depth: one in flight in the window stage plus a spare
    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

    typedef struct packed
    {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               is_point;
        logic               frame_end;
        logic [COUNT_W-1:0] point_count;
    } result_t;

    // limit a programmed dimension to the supported range
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(MIN_DIM))
        begin
            r = DIM_W'(MIN_DIM);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

### rtl/core/mcpe_if.sv
// ----------------------------------------------------------------------------
// mcpe_pixel_if / mcpe_result_if
// valid/ready channels of the mask contour point extractor
// ----------------------------------------------------------------------------
interface mcpe_pixel_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mcpe_pkg::PIXEL_W-1:0]   pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mcpe_result_if;
    logic                            valid;
    logic                            ready;
    logic [mcpe_pkg::COORD_W-1:0]    point_x;
    logic [mcpe_pkg::COORD_W-1:0]    point_y;
    logic                            is_point;
    logic                            frame_end;
    logic [mcpe_pkg::COUNT_W-1:0]    point_count;

    modport source (output valid, output point_x, output point_y, output is_point,
                    output frame_end, output point_count, input ready);
    modport sink   (input valid, input point_x, input point_y, input is_point,
                    input frame_end, input point_count, output ready);
endinterface

### rtl/core/mcpe_ram.sv
// ----------------------------------------------------------------------------
// mcpe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mcpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/mcpe_result_queue.sv
// ----------------------------------------------------------------------------
// mcpe_result_queue
// small result fifo that decouples the window stage from the output channel
// ----------------------------------------------------------------------------
module mcpe_result_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  mcpe_pkg::result_t                 push_data,
    output logic [mcpe_pkg::QUEUE_CNT_W-1:0]  count,
    mcpe_result_if.source                     result
);

    mcpe_pkg::result_t                       slot_reg [mcpe_pkg::QUEUE_DEPTH];
    logic [mcpe_pkg::QUEUE_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mcpe_pkg::QUEUE_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [mcpe_pkg::QUEUE_CNT_W-1:0]        count_reg, count_next;
    logic                                    pop;
    mcpe_pkg::result_t                       head;

    assign pop  = result.valid && result.ready;
    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mcpe_pkg::QUEUE_PTR_W'(mcpe_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mcpe_pkg::QUEUE_PTR_W'(mcpe_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count              = count_reg;
    assign result.valid       = (count_reg != '0);
    assign result.point_x     = head.point_x;
    assign result.point_y     = head.point_y;
    assign result.is_point    = head.is_point;
    assign result.frame_end   = head.frame_end;
    assign result.point_count = head.point_count;

endmodule

### rtl/core/mask_contour_point_extractor_unit.sv
// ----------------------------------------------------------------------------
// mask_contour_point_extractor_unit
// finds zero pixels of a raster mask, clear of the border, that touch a nonzero 8-neighbour
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | item
//  ---------+-----+----------------+----------------------------------------
//  pixel    | in  | valid/ready    | pixel_value, one pixel in raster order
//  result   | out | valid/ready    | point_x, point_y, is_point, frame_end,
//           |     |                | point_count
//  apb      | in  | psel/penable   | frame_width (0x0), frame_height (0x4)
//
//  one pixel per clock sustained; a pixel reads its column of the line
//  store ram on acceptance and its window update and write-back happen in
//  the next cycle, so the ram port pair sets the one-cycle pace
//  a result is registered in the window stage and then held in the result queue before it leaves
//  reset clears counters, window and queue; the line store has no reset
//  input stalls only when the result queue could not absorb the item in flight
//
module mask_contour_point_extractor_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,

    mcpe_pixel_if.sink                            pixel,
    mcpe_result_if.source                         result,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mcpe_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [mcpe_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [mcpe_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int CW = mcpe_pkg::COORD_W;
    localparam int DW = mcpe_pkg::DIM_W;

    // configuration registers
    logic [DW-1:0]  frame_width_reg, frame_height_reg;
    logic           cfg_write;
    logic [DW-1:0]  width_eff, height_eff;

    // pixel position of the next item
    logic [CW-1:0]  col_reg, col_next;
    logic [CW-1:0]  row_reg, row_next;
    logic           accept;
    logic           last_col;
    logic           last_row;

    // window stage
    logic           s1_valid_reg;
    logic           s1_cur_reg;
    logic [CW-1:0]  s1_col_reg;
    logic [CW-1:0]  s1_row_reg;
    logic [8:0]     window_reg, window_next;
    logic [mcpe_pkg::COUNT_W-1:0] points_found_reg, points_found_next;

    logic [mcpe_pkg::LINE_ENTRY_W-1:0] line_rdata;
    logic [mcpe_pkg::LINE_ENTRY_W-1:0] line_wdata;
    logic           up_flag, mid_flag;

    logic           in_border;
    logic           hit;
    logic           s1_last_col, s1_last_row, s1_frame_last;
    logic [mcpe_pkg::COUNT_W-1:0] count_inc;
    logic           push;
    mcpe_pkg::result_t push_data;
    logic [mcpe_pkg::QUEUE_CNT_W-1:0] queue_count;
    logic [mcpe_pkg::QUEUE_CNT_W:0]   occupancy;

    // ------------------------------------------------------------------
    // configuration port, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= mcpe_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= mcpe_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (mcpe_pkg::reg_index_t'(paddr[2]))
                mcpe_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DW-1:0];
                mcpe_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (mcpe_pkg::reg_index_t'(paddr[2]))
            mcpe_pkg::REG_FRAME_WIDTH:
                prdata = {{(mcpe_pkg::APB_DATA_W - DW){1'b0}}, frame_width_reg};
            mcpe_pkg::REG_FRAME_HEIGHT:
                prdata = {{(mcpe_pkg::APB_DATA_W - DW){1'b0}}, frame_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // dimensions in use, limited to the supported range
    assign width_eff  = mcpe_pkg::clamp_dim(frame_width_reg,  DW'(mcpe_pkg::MAX_WIDTH));
    assign height_eff = mcpe_pkg::clamp_dim(frame_height_reg, DW'(mcpe_pkg::MAX_HEIGHT));

    // ------------------------------------------------------------------
    // accept stage: raster counters and line store read
    // ------------------------------------------------------------------
    // an item is let in only when the queue can hold every result in flight
    assign occupancy   = {1'b0, queue_count} + {{mcpe_pkg::QUEUE_CNT_W{1'b0}}, s1_valid_reg};
    assign pixel.ready = (occupancy < (mcpe_pkg::QUEUE_CNT_W + 1)'(mcpe_pkg::QUEUE_DEPTH));
    assign accept      = pixel.valid && pixel.ready;

    assign last_col = ({1'b0, col_reg} + 1'b1) >= width_eff;
    assign last_row = ({1'b0, row_reg} + 1'b1) >= height_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg <= (pixel.pixel_value != '0);
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    // line store: entry per column holds the two previous rows' flags.
    // consecutive items always hit different columns, so the write-back
    // of one item never collides with the read of the next
    mcpe_ram #(
        .WIDTH (mcpe_pkg::LINE_ENTRY_W),
        .DEPTH (mcpe_pkg::LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // ------------------------------------------------------------------
    // window stage: shift window, write back, detect points
    // ------------------------------------------------------------------
    assign up_flag    = line_rdata[1];
    assign mid_flag   = line_rdata[0];
    // rows move up by one: middle becomes upper, current becomes middle
    assign line_wdata = {mid_flag, s1_cur_reg};

    // top row in bit 0 of each column, newest column in the low bits
    assign window_next = {window_reg[5:0], s1_cur_reg, mid_flag, up_flag};

    // center trails the item by one column and one row
    assign in_border = (s1_col_reg >= CW'(mcpe_pkg::BORDER + 1))
                    && (({1'b0, s1_col_reg} + DW'(mcpe_pkg::BORDER)) <= width_eff)
                    && (s1_row_reg >= CW'(mcpe_pkg::BORDER + 1))
                    && (({1'b0, s1_row_reg} + DW'(mcpe_pkg::BORDER)) <= height_eff);

    // zero center with any nonzero neighbour
    assign hit = in_border && !window_next[4] && ((window_next & 9'h1EF) != '0);

    assign count_inc = (hit && (points_found_reg != mcpe_pkg::COUNT_MAX))
                     ? points_found_reg + 1'b1 : points_found_reg;

    assign s1_last_col   = ({1'b0, s1_col_reg} + 1'b1) >= width_eff;
    assign s1_last_row   = ({1'b0, s1_row_reg} + 1'b1) >= height_eff;
    assign s1_frame_last = s1_last_col && s1_last_row;

    assign points_found_next = s1_frame_last ? '0 : count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= '0;
            points_found_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            window_reg       <= window_next;
            points_found_reg <= points_found_next;
        end
    end

    // frame end never coincides with a point: the last pixel lies outside
    always_comb
    begin
        push_data.point_count = count_inc;
        if (s1_frame_last)
        begin
            push_data.point_x   = '0;
            push_data.point_y   = '0;
            push_data.is_point  = 1'b0;
            push_data.frame_end = 1'b1;
        end
        else
        begin
            push_data.point_x   = s1_col_reg - 1'b1;
            push_data.point_y   = s1_row_reg - 1'b1;
            push_data.is_point  = 1'b1;
            push_data.frame_end = 1'b0;
        end
    end

    assign push = s1_valid_reg && (hit || s1_frame_last);

    mcpe_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (queue_count),
        .result    (result)
    );

endmodule

### bench/contour_point_checker.sv
// ----------------------------------------------------------------------------
// contour_point_checker
// watches the pixel, result and register ports of the contour point
// extractor, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module contour_point_checker
    import mcpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    mcpe_pixel_if                 pixel,
    mcpe_result_if                result,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,

    output int                    mismatch_count,
    output int                    results_pending,
    output int                    points_seen,
    output int                    frames_seen
);

    // keep the log short when something goes badly wrong
    localparam int PRINT_CAP = 100;

    logic [DIM_W-1:0]     reg_width;
    logic [DIM_W-1:0]     reg_height;
    logic [MAX_WIDTH-1:0] row_above;
    logic [MAX_WIDTH-1:0] row_middle;
    logic [8:0]           window;
    logic [COORD_W-1:0]   col_pos;
    logic [COORD_W-1:0]   row_pos;
    logic [COUNT_W-1:0]   frame_points;
    result_t              contour_results_due[$];
    int                   mismatch_total;
    int                   point_total;
    int                   frame_total;
    int                   result_index;

    function automatic int dim_limit(input logic [DIM_W-1:0] raw, input int hi);
        int v;
        v = int'(raw);
        if (v < MIN_DIM)
        begin
            v = MIN_DIM;
        end
        else if (v > hi)
        begin
            v = hi;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_total < PRINT_CAP)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_total++;
    endtask

    task automatic compare_field(input string name, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      result_index, name, got, want));
        end
    endtask

    // one pixel through the window: line stores, flag window, counters
    task automatic predict_contour(input logic signed [PIXEL_W-1:0] value);
        int      w;
        int      h;
        int      col;
        int      row;
        int      cx;
        int      cy;
        logic    cur;
        logic    up;
        logic    mid;
        result_t r;
        w   = dim_limit(reg_width, MAX_WIDTH);
        h   = dim_limit(reg_height, MAX_HEIGHT);
        col = int'(col_pos);
        row = int'(row_pos);
        cur = (value != 0);
        up  = row_above[col];
        mid = row_middle[col];
        row_above[col]  = mid;
        row_middle[col] = cur;
        // newest column lowest, top row in bit 0 of each column
        window = {window[5:0], cur, mid, up};
        if (col >= 1 && row >= 1)
        begin
            cx = col - 1;
            cy = row - 1;
            if (cx >= BORDER && cx + BORDER + 1 <= w && cy >= BORDER && cy + BORDER + 1 <= h
                && !window[4] && (window & 9'h1EF) != 9'h000)
            begin
                if (frame_points != COUNT_MAX)
                begin
                    frame_points = frame_points + 1'b1;
                end
                r.point_x     = COORD_W'(cx);
                r.point_y     = COORD_W'(cy);
                r.is_point    = 1'b1;
                r.frame_end   = 1'b0;
                r.point_count = frame_points;
                contour_results_due.push_back(r);
            end
        end
        if (col + 1 >= w)
        begin
            col_pos = '0;
            if (row + 1 >= h)
            begin
                r.point_x     = '0;
                r.point_y     = '0;
                r.is_point    = 1'b0;
                r.frame_end   = 1'b1;
                r.point_count = frame_points;
                contour_results_due.push_back(r);
                row_pos      = '0;
                frame_points = '0;
            end
            else
            begin
                row_pos = COORD_W'(row + 1);
            end
        end
        else
        begin
            col_pos = COORD_W'(col + 1);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (contour_results_due.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing due: x=%0d y=%0d pt=%0b end=%0b n=%0d",
                                      result.point_x, result.point_y, result.is_point,
                                      result.frame_end, result.point_count));
        end
        else
        begin
            want = contour_results_due.pop_front();
            compare_field("point_x", COUNT_W'(result.point_x), COUNT_W'(want.point_x));
            compare_field("point_y", COUNT_W'(result.point_y), COUNT_W'(want.point_y));
            compare_field("is_point", COUNT_W'(result.is_point), COUNT_W'(want.is_point));
            compare_field("frame_end", COUNT_W'(result.frame_end), COUNT_W'(want.frame_end));
            compare_field("point_count", result.point_count, want.point_count);
            if (want.is_point)
            begin
                point_total++;
            end
            if (want.frame_end)
            begin
                frame_total++;
            end
        end
        result_index++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_width      = FRAME_WIDTH_RESET;
            reg_height     = FRAME_HEIGHT_RESET;
            row_above      = '0;
            row_middle     = '0;
            window         = '0;
            col_pos        = '0;
            row_pos        = '0;
            frame_points   = '0;
            mismatch_total = 0;
            point_total    = 0;
            frame_total    = 0;
            result_index   = 0;
            contour_results_due.delete();
        end
        else
        begin
            // results leave only after their pixel has passed the window stage and the queue, so older first
            if (result.valid && result.ready)
            begin
                check_result();
            end
            if (pixel.valid && pixel.ready)
            begin
                predict_contour(pixel.pixel_value);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_FRAME_WIDTH:  reg_width  = pwdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT: reg_height = pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatch_count  <= mismatch_total;
        results_pending <= contour_results_due.size();
        points_seen     <= point_total;
        frames_seen     <= frame_total;
    end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the mask contour point extractor: directed and
// random raster frames, register writes between and inside frames, random
// idling on both channels and a long result stall
// ----------------------------------------------------------------------------
module tb_top;
    import mcpe_pkg::*;

    // quiet cycles after the last result before touching a register
    localparam int SETTLE_CYCLES  = 8;
    // cycles without any item moving before the run is declared hung
    localparam int STALL_LIMIT    = 4000;
    // pixels in the random frame part
    localparam int RANDOM_PIXELS  = 1150;
    // length of the result-side hold that backs the block up
    localparam int HOLD_CYCLES    = 400;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int results_pending;
    int points_seen;
    int frames_seen;

    // idling switches and the hold request, shared by the driving processes
    bit src_idle;
    bit sink_idle;
    int result_hold_cycles = 0;
    int pixels_sent = 0;
    int idle_run = 0;

    mcpe_pixel_if  pixel_ch ();
    mcpe_result_if result_ch ();

    mask_contour_point_extractor_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    contour_point_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel           (pixel_ch),
        .result          (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .points_seen     (points_seen),
        .frames_seen     (frames_seen)
    );

    // 8 time unit clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // pixel values
    // ------------------------------------------------------------------

    // any nonzero value: full random, single bits, minus one and the signed extremes
    function automatic logic signed [PIXEL_W-1:0] pick_nonzero();
        logic signed [PIXEL_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom();
            1:       v = PIXEL_W'(1) << $urandom_range(0, PIXEL_W - 1);
            2:       v = -1;
            default: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
        if (v == 0)
        begin
            v = 1;
        end
        return v;
    endfunction

    // density in eighths: 0 gives an empty mask, 8 a full one
    function automatic logic signed [PIXEL_W-1:0] pick_pixel(input int density);
        return ($urandom_range(0, 7) < density) ? pick_nonzero() : '0;
    endfunction

    // ------------------------------------------------------------------
    // channel and register drivers
    // ------------------------------------------------------------------

    // offer one pixel, after a random gap when the source idles, and wait for it to be taken
    task automatic send_pixel(input logic signed [PIXEL_W-1:0] value);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid       <= 1'b1;
        pixel_ch.pixel_value <= value;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count, input int density);
        repeat (count) send_pixel(pick_pixel(density));
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic wait_for_results();
        pixel_ch.valid <= 1'b0;
        // wait for an edge so the checker has seen the last pixel
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        // a last pixel with no result may still sit in the window stage
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup phase, access phase, then the bus returns to idle
    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(input int raw_w, input int raw_h);
        write_reg(REG_FRAME_WIDTH, APB_DATA_W'(raw_w));
        write_reg(REG_FRAME_HEIGHT, APB_DATA_W'(raw_h));
    endtask

    task automatic pick_idle();
        src_idle  = $urandom_range(0, 1);
        sink_idle = $urandom_range(0, 1);
    endtask

    // ------------------------------------------------------------------
    // result side: random ready gaps, plus a long hold when asked for
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        int stretch;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (result_hold_cycles > 0)
            begin
                stretch            = result_hold_cycles;
                result_hold_cycles = 0;
                result_ch.ready <= 1'b0;
                repeat (stretch) @(posedge clk);
            end
            gap = sink_idle ? $urandom_range(0, 16) : 0;
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            // leave early when a hold is requested so it starts at once
            do
                @(posedge clk);
            while (!result_ch.valid && result_hold_cycles == 0);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: nothing moving on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_run <= 0;
            end
            else
            begin
                idle_run <= idle_run + 1;
            end
            if (idle_run >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int eff_w;
        int eff_h;
        int raw_w;
        int raw_h;
        int random_start;
        bit reconfigure;

        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        pixel_ch.valid       <= 1'b0;
        pixel_ch.pixel_value <= '0;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, one center at (3,3): zero center with the signed
        // extremes as diagonal neighbours, -1 and 1 in the far corners
        set_dims(7, 7);
        for (int i = 0; i < 49; i++)
        begin
            case (i)
                0:       send_pixel(-1);
                16:      send_pixel(32'sh8000_0000);
                32:      send_pixel(32'sh7FFF_FFFF);
                48:      send_pixel(1);
                default: send_pixel('0);
            endcase
        end
        wait_for_results();

        // dimensions below range clamp to 7; a full mask gives no point and
        // a zero count on the frame end
        set_dims(0, 6);
        repeat (49) send_pixel(pick_nonzero());
        wait_for_results();

        // size writes inside a frame, each with the block drained first
        pick_idle();
        set_dims(20, 12);
        // stop at row 5 column 7
        send_pixels(107, 4);
        wait_for_results();
        // narrower rows from here on
        write_reg(REG_FRAME_WIDTH, APB_DATA_W'(15));
        // rest of row 5, row 6, then up to row 7 column 5
        send_pixels(28, 4);
        wait_for_results();
        // shorter frame: it now ends with row 8
        write_reg(REG_FRAME_HEIGHT, APB_DATA_W'(9));
        send_pixels(25, 4);
        wait_for_results();

        // long result stall under a dense mask so the result queue fills and
        // the pixel input backs up while the sender keeps offering
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_dims(24, 16);
        result_hold_cycles = HOLD_CYCLES;
        send_pixels(24 * 16, 4);
        wait_for_results();

        // random frames, mostly small; some run straight into the next frame
        // with no pause and no register write
        random_start = pixels_sent;
        reconfigure  = 1'b1;
        eff_w        = 7;
        eff_h        = 7;
        while (pixels_sent - random_start < RANDOM_PIXELS)
        begin
            if (reconfigure)
            begin
                wait_for_results();
                pick_idle();
                eff_w = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64)
                                                    : $urandom_range(7, 24);
                eff_h = $urandom_range(7, 16);
                raw_w = eff_w;
                raw_h = eff_h;
                if ($urandom_range(0, 5) == 0)
                begin
                    eff_w = 7;
                    raw_w = $urandom_range(0, 7);
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    eff_h = 7;
                    raw_h = $urandom_range(0, 7);
                end
                set_dims(raw_w, raw_h);
            end
            send_pixels(eff_w * eff_h, $urandom_range(0, 8));
            reconfigure = ($urandom_range(0, 2) != 0);
        end

        // drain and give the block time to show any stray result
        wait_for_results();
        repeat (20) @(posedge clk);

        $display("covered %0d frames, %0d contour points, %0d pixels",
                 frames_seen, points_seen, pixels_sent);
        $display("sizes 7x7 to 64x16, low clamping, mid-frame size writes, long result stall");
        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
